/* rtl/assert_macros.svh */
// Assertion macros for the split and dividend adjustment ratio unit.
// Each macro expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SDAR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDAR_ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDAR_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SDAR_ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

/* rtl/sdar_pkg.sv */
// Package for the split and dividend adjustment ratio unit: widths, fixed-point
// constants, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package sdar_pkg;

    localparam int RATIO_FRAC_BITS = 24;
    localparam int RATIO_W         = 32;
    localparam int PRICE_W         = 40;
    localparam int PROD_W          = 2 * RATIO_W;
    localparam int DIV_CNT_W       = $clog2(RATIO_FRAC_BITS);

    localparam logic [RATIO_W-1:0] RATIO_ONE  = {{(RATIO_W-1){1'b0}}, 1'b1} << RATIO_FRAC_BITS;
    localparam logic [PROD_W-1:0]  ROUND_HALF =
        {{(PROD_W-1){1'b0}}, 1'b1} << (RATIO_FRAC_BITS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RATIO_FRAC_BITS - 1);

    localparam logic MUL_SPLIT = 1'b0;
    localparam logic MUL_DIV   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_S,
        ST_RND_S,
        ST_MUL_D,
        ST_RND_D,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_en;
        logic mul_sel;
        logic rnd_split;
        logic rnd_div;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

/* rtl/sdar_ctrl.sv */
// Controller for the split and dividend adjustment ratio unit.
// Sequences divide, multiply, round and output steps. Uses sdar_pkg.
`timescale 1ns / 1ps
module sdar_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sdar_pkg::t_sts i_sts,
    output sdar_pkg::t_cmd o_cmd
);
    import sdar_pkg::*;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_MUL_S;
                end
            end
            ST_MUL_S: n_state = ST_RND_S;
            ST_RND_S: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_RND_D;
            ST_RND_D: n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_DIV: o_cmd.div_step = 1'b1;
            ST_MUL_S: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SPLIT;
            end
            ST_RND_S: o_cmd.rnd_split = 1'b1;
            ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DIV;
            end
            ST_RND_D: o_cmd.rnd_div = 1'b1;
            ST_DONE: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/sdar_dpath.sv */
// Datapath for the split and dividend adjustment ratio unit: restoring
// divider, shared multiplier, rounding, running products, output register.
// Uses sdar_pkg.
`timescale 1ns / 1ps
module sdar_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sdar_pkg::t_cmd               i_cmd,
    output sdar_pkg::t_sts               o_sts,
    input  logic [sdar_pkg::RATIO_W-1:0] i_split_factor,
    input  logic                         i_split_present,
    input  logic [sdar_pkg::PRICE_W-1:0] i_dividend_amount,
    input  logic                         i_dividend_present,
    input  logic [sdar_pkg::PRICE_W-1:0] i_older_close,
    input  logic                         i_restart,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [sdar_pkg::RATIO_W-1:0] o_split_ratio_out,
    output logic [sdar_pkg::RATIO_W-1:0] o_dividend_ratio_out,
    output logic                         o_saturated,
    output logic                         o_bad_close
);
    import sdar_pkg::*;

    logic [RATIO_W-1:0]         r_split_factor;
    logic                       r_split_present;
    logic                       r_div_present;
    logic                       r_bad;
    logic [PRICE_W-1:0]         r_den;
    logic [PRICE_W-1:0]         r_rem;
    logic [RATIO_FRAC_BITS-1:0] r_quo;
    logic [RATIO_W-1:0]         r_split_prod;
    logic [RATIO_W-1:0]         r_div_prod;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_sat;
    logic                       r_out_valid;
    logic [RATIO_W-1:0]         r_out_split;
    logic [RATIO_W-1:0]         r_out_div;
    logic                       r_out_sat;
    logic                       r_out_bad;

    logic [PRICE_W:0]   w_rem2;
    logic [PRICE_W:0]   w_diff;
    logic               w_ge;
    logic [RATIO_W-1:0] w_factor;
    logic [RATIO_W-1:0] w_mul_a;
    logic [RATIO_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_rnd;
    logic [PROD_W-1:0]  w_shr;
    logic               w_ovf;
    logic [RATIO_W-1:0] w_rnd_val;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_diff = w_rem2 - {1'b0, r_den};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    assign w_factor = r_bad ? '0 : (RATIO_ONE - RATIO_W'(r_quo));
    assign w_mul_a  = (i_cmd.mul_sel == MUL_DIV) ? r_div_prod : r_split_prod;
    assign w_mul_b  = (i_cmd.mul_sel == MUL_DIV) ? w_factor : r_split_factor;

    assign w_rnd     = r_prod + ROUND_HALF;
    assign w_shr     = w_rnd >> RATIO_FRAC_BITS;
    assign w_ovf     = |w_shr[PROD_W-1:RATIO_W];
    assign w_rnd_val = w_ovf ? '1 : w_shr[RATIO_W-1:0];

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_prod <= RATIO_ONE;
            r_div_prod   <= RATIO_ONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_restart) begin
                    r_split_prod <= RATIO_ONE;
                    r_div_prod   <= RATIO_ONE;
                end
            end
            if (i_cmd.rnd_split && r_split_present) begin
                r_split_prod <= w_rnd_val;
            end
            if (i_cmd.rnd_div && r_div_present) begin
                r_div_prod <= w_rnd_val;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_split_factor  <= i_split_factor;
            r_split_present <= i_split_present;
            r_div_present   <= i_dividend_present;
            r_bad           <= i_dividend_present && (i_older_close <= i_dividend_amount);
            r_den           <= i_older_close;
            r_rem           <= i_dividend_amount;
            r_quo           <= '0;
            r_sat           <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[PRICE_W-1:0] : w_rem2[PRICE_W-1:0];
            r_quo <= {r_quo[RATIO_FRAC_BITS-2:0], w_ge};
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
        if ((i_cmd.rnd_split && r_split_present) || (i_cmd.rnd_div && r_div_present)) begin
            r_sat <= r_sat || w_ovf;
        end
        if (i_cmd.out_load) begin
            r_out_split <= r_split_prod;
            r_out_div   <= r_div_prod;
            r_out_sat   <= r_sat;
            r_out_bad   <= r_bad;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_split_ratio_out    = r_out_split;
    assign o_dividend_ratio_out = r_out_div;
    assign o_saturated          = r_out_sat;
    assign o_bad_close          = r_out_bad;

endmodule

/* rtl/split_dividend_adjust_ratios_unit.sv */
// A beat passes through the restoring divider (one quotient bit a cycle), then the
// shared multiplier and rounding, for the split and then the dividend product; a new
// beat is taken only after the result has been loaded into the output register.
// The output register holds a result while the next beat is taken.
// Reset: synchronous, active low; both running products return to 1.0.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module split_dividend_adjust_ratios_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [sdar_pkg::RATIO_W-1:0] i_split_factor,
    input  logic                         i_split_present,
    input  logic [sdar_pkg::PRICE_W-1:0] i_dividend_amount,
    input  logic                         i_dividend_present,
    input  logic [sdar_pkg::PRICE_W-1:0] i_older_close,
    input  logic                         i_restart,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sdar_pkg::RATIO_W-1:0] o_split_ratio_out,
    output logic [sdar_pkg::RATIO_W-1:0] o_dividend_ratio_out,
    output logic                         o_saturated,
    output logic                         o_bad_close
);
    import sdar_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sdar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sdar_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_split_factor       (i_split_factor),
        .i_split_present      (i_split_present),
        .i_dividend_amount    (i_dividend_amount),
        .i_dividend_present   (i_dividend_present),
        .i_older_close        (i_older_close),
        .i_restart            (i_restart),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_split_ratio_out    (o_split_ratio_out),
        .o_dividend_ratio_out (o_dividend_ratio_out),
        .o_saturated          (o_saturated),
        .o_bad_close          (o_bad_close)
    );

    `SDAR_ASSERT_ALW(a_reset_idle, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "reset did not idle the unit")
    `SDAR_ASSERT_RST(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load |-> w_sts.out_free, "output register overwritten")
    `SDAR_ASSERT_RST(a_one_cmd, i_clk, i_rst_n, $onehot0({w_cmd.load, w_cmd.div_step, w_cmd.mul_en, w_cmd.rnd_split, w_cmd.rnd_div, w_cmd.out_load}), "more than one datapath command")
    `SDAR_ASSERT_RST(a_busy_after_beat, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> (o_in_stall && !w_cmd.load), "second beat taken while busy")

endmodule

/* sim/split_dividend_adjust_ratios_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for split_dividend_adjust_ratios_unit: a directed run, then random
// price-history beats with idle and stall on both channels, scored by a bit-true predictor.
// Depends on sdar_pkg and the unit itself.
module split_dividend_adjust_ratios_unit_test;

    import sdar_pkg::RATIO_W;
    import sdar_pkg::PRICE_W;
    import sdar_pkg::RATIO_FRAC_BITS;
    import sdar_pkg::RATIO_ONE;

    localparam logic [PRICE_W-1:0] PRICE_ONE   = 40'h00_0001_0000;
    localparam logic [PRICE_W-1:0] PRICE_MAX   = {PRICE_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_MAX   = {RATIO_W{1'b1}};
    localparam int unsigned        RANDOM_BEATS = 500;
    localparam int unsigned        CYCLE_LIMIT  = 300000;
    localparam int unsigned        DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [RATIO_W-1:0] split_factor;
        logic               split_present;
        logic [PRICE_W-1:0] dividend_amount;
        logic               dividend_present;
        logic [PRICE_W-1:0] older_close;
        logic               restart;
    } price_beat_t;

    typedef struct packed {
        logic [RATIO_W-1:0] split_ratio;
        logic [RATIO_W-1:0] dividend_ratio;
        logic               saturated;
        logic               bad_close;
    } ratio_result_t;

    class ratio_scoreboard;
        logic [RATIO_W-1:0] split_prod;
        logic [RATIO_W-1:0] div_prod;
        ratio_result_t      pending[$];
        int unsigned        errors;
        int unsigned        beats;
        int unsigned        checked;
        int unsigned        sat_count;
        int unsigned        bad_count;
        int unsigned        restart_count;

        function new();
            split_prod    = RATIO_ONE;
            div_prod      = RATIO_ONE;
            errors        = 0;
            beats         = 0;
            checked       = 0;
            sat_count     = 0;
            bad_count     = 0;
            restart_count = 0;
        endfunction

        // Return {clipped, value}: product rounded half up, clipped to 32 bits.
        function logic [RATIO_W:0] scale_ratio(logic [RATIO_W-1:0] a, logic [RATIO_W-1:0] b);
            logic [2*RATIO_W:0] prod;
            prod = (2*RATIO_W+1)'(a) * (2*RATIO_W+1)'(b);
            prod = prod + (2*RATIO_W+1)'(1) << 0;
            prod = prod - 1 + ((2*RATIO_W+1)'(1) << (RATIO_FRAC_BITS - 1));
            prod = prod >> RATIO_FRAC_BITS;
            if (prod > (2*RATIO_W+1)'(RATIO_MAX))
                return {1'b1, RATIO_MAX};
            return {1'b0, prod[RATIO_W-1:0]};
        endfunction

        function logic [RATIO_W-1:0] dividend_factor(logic [PRICE_W-1:0] amount,
                                                     logic [PRICE_W-1:0] close);
            logic [PRICE_W+RATIO_FRAC_BITS-1:0] scaled;
            logic [PRICE_W+RATIO_FRAC_BITS-1:0] quot;
            scaled = amount;
            scaled = scaled << RATIO_FRAC_BITS;
            quot   = scaled / (PRICE_W+RATIO_FRAC_BITS)'(close);
            return RATIO_ONE - quot[RATIO_W-1:0];
        endfunction

        function void note_input(price_beat_t beat);
            ratio_result_t      want;
            logic [RATIO_W:0]   scaled;
            logic [RATIO_W-1:0] factor;
            want = '0;
            beats++;
            if (beat.restart) begin
                split_prod = RATIO_ONE;
                div_prod   = RATIO_ONE;
                restart_count++;
            end
            if (beat.split_present) begin
                scaled         = scale_ratio(split_prod, beat.split_factor);
                split_prod     = scaled[RATIO_W-1:0];
                want.saturated = scaled[RATIO_W];
            end
            if (beat.dividend_present) begin
                if (beat.older_close == '0 || beat.older_close <= beat.dividend_amount) begin
                    factor         = '0;
                    want.bad_close = 1'b1;
                end else begin
                    factor = dividend_factor(beat.dividend_amount, beat.older_close);
                end
                scaled         = scale_ratio(div_prod, factor);
                div_prod       = scaled[RATIO_W-1:0];
                want.saturated = want.saturated | scaled[RATIO_W];
            end
            want.split_ratio    = split_prod;
            want.dividend_ratio = div_prod;
            sat_count += want.saturated;
            bad_count += want.bad_close;
            pending.push_back(want);
        endfunction

        function void check_result(ratio_result_t got);
            ratio_result_t want;
            if (pending.size() == 0) begin
                $error("result with no beat outstanding: split %h dividend %h",
                       got.split_ratio, got.dividend_ratio);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.split_ratio !== want.split_ratio) begin
                $error("split_ratio_out: expected %h, got %h", want.split_ratio, got.split_ratio);
                errors++;
            end
            if (got.dividend_ratio !== want.dividend_ratio) begin
                $error("dividend_ratio_out: expected %h, got %h",
                       want.dividend_ratio, got.dividend_ratio);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %b, got %b", want.saturated, got.saturated);
                errors++;
            end
            if (got.bad_close !== want.bad_close) begin
                $error("bad_close: expected %b, got %b", want.bad_close, got.bad_close);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [RATIO_W-1:0] i_split_factor;
    logic               i_split_present;
    logic [PRICE_W-1:0] i_dividend_amount;
    logic               i_dividend_present;
    logic [PRICE_W-1:0] i_older_close;
    logic               i_restart;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [RATIO_W-1:0] o_split_ratio_out;
    logic [RATIO_W-1:0] o_dividend_ratio_out;
    logic               o_saturated;
    logic               o_bad_close;

    ratio_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int unsigned     cycle_count;

    split_dividend_adjust_ratios_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_split_factor      (i_split_factor),
        .i_split_present     (i_split_present),
        .i_dividend_amount   (i_dividend_amount),
        .i_dividend_present  (i_dividend_present),
        .i_older_close       (i_older_close),
        .i_restart           (i_restart),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_split_ratio_out   (o_split_ratio_out),
        .o_dividend_ratio_out(o_dividend_ratio_out),
        .o_saturated         (o_saturated),
        .o_bad_close         (o_bad_close)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic price_beat_t make_beat(logic [RATIO_W-1:0] split_factor,
                                              logic split_present,
                                              logic [PRICE_W-1:0] amount,
                                              logic dividend_present,
                                              logic [PRICE_W-1:0] close,
                                              logic restart);
        price_beat_t beat;
        beat.split_factor     = split_factor;
        beat.split_present    = split_present;
        beat.dividend_amount  = amount;
        beat.dividend_present = dividend_present;
        beat.older_close      = close;
        beat.restart          = restart;
        return beat;
    endfunction

    function automatic price_beat_t random_beat();
        price_beat_t beat;
        int unsigned pick;
        beat.restart       = ($urandom_range(11) == 0);
        beat.split_present = ($urandom_range(99) < 30);
        pick = $urandom_range(9);
        if (pick < 6)
            beat.split_factor = $urandom_range(32'h0200_0000, 32'h0080_0000);
        else if (pick == 6)
            beat.split_factor = $urandom_range(255);
        else if (pick == 7)
            beat.split_factor = $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
        else
            beat.split_factor = $urandom;
        beat.dividend_present = ($urandom_range(99) < 40);
        if ($urandom_range(3) == 0)
            beat.older_close = {8'($urandom), 32'($urandom)};
        else
            beat.older_close = 40'($urandom);
        pick = $urandom_range(19);
        if (pick < 14) begin
            beat.dividend_amount = beat.older_close / $urandom_range(200, 2);
        end else if (pick == 14) begin
            beat.older_close     = '0;
            beat.dividend_amount = {8'($urandom), 32'($urandom)};
        end else if (pick == 15) begin
            beat.dividend_amount = beat.older_close;
        end else if (pick == 16) begin
            beat.dividend_amount = beat.older_close - 1;
        end else begin
            beat.dividend_amount = {8'($urandom), 32'($urandom)};
        end
        return beat;
    endfunction

    task automatic send_beat(input price_beat_t beat);
        bit accepted;
        i_in_valid         <= 1'b1;
        i_split_factor     <= beat.split_factor;
        i_split_present    <= beat.split_present;
        i_dividend_amount  <= beat.dividend_amount;
        i_dividend_present <= beat.dividend_present;
        i_older_close      <= beat.older_close;
        i_restart          <= beat.restart;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge i_clk);
            accepted = !o_in_stall;
            @(posedge i_clk);
        end
        sb.note_input(beat);
    endtask

    task automatic idle_input();
        int unsigned gap;
        if (idle_on && $urandom_range(99) < 23) begin
            gap = $urandom_range(12, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_split_ratio_out, o_dividend_ratio_out, o_saturated, o_bad_close});
    end

    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 23);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        price_beat_t directed[$];
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_split_factor     <= '0;
        i_split_present    <= 1'b0;
        i_dividend_amount  <= '0;
        i_dividend_present <= 1'b0;
        i_older_close      <= '0;
        i_restart          <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(make_beat('0, 1'b0, '0, 1'b0, '0, 1'b0));
        directed.push_back(make_beat(RATIO_ONE << 1, 1'b1, '0, 1'b0, '0, 1'b0));
        directed.push_back(make_beat(RATIO_MAX, 1'b1, '0, 1'b0, '0, 1'b0));
        directed.push_back(make_beat(RATIO_MAX, 1'b1, '0, 1'b0, '0, 1'b0));
        directed.push_back(make_beat(RATIO_ONE, 1'b1, '0, 1'b0, '0, 1'b1));
        directed.push_back(make_beat('0, 1'b0, PRICE_ONE, 1'b1, PRICE_ONE * 100, 1'b0));
        directed.push_back(make_beat('0, 1'b0, '0, 1'b1, '0, 1'b0));
        directed.push_back(make_beat('0, 1'b0, PRICE_MAX, 1'b1, PRICE_MAX, 1'b1));
        directed.push_back(make_beat('0, 1'b1, PRICE_MAX, 1'b1, PRICE_ONE, 1'b1));
        directed.push_back(make_beat(RATIO_ONE * 3, 1'b1, '0, 1'b0, '0, 1'b0));
        directed.push_back(make_beat('0, 1'b0, '0, 1'b1, PRICE_MAX, 1'b1));
        directed.push_back(make_beat('0, 1'b0, PRICE_MAX - 1, 1'b1, PRICE_MAX, 1'b0));
        directed.push_back(make_beat(32'h0000_0001, 1'b1, 40'h1, 1'b1, PRICE_MAX, 1'b1));
        directed.push_back(make_beat(RATIO_ONE >> 1, 1'b1, 40'd5, 1'b1, 40'd10, 1'b1));
        directed.push_back(make_beat(RATIO_MAX, 1'b0, PRICE_MAX, 1'b0, PRICE_MAX, 1'b1));
        directed.push_back(make_beat(RATIO_MAX, 1'b1, PRICE_MAX - 1, 1'b1, PRICE_MAX, 1'b0));
        directed.push_back(make_beat(32'h0155_5555, 1'b1, PRICE_ONE, 1'b1, PRICE_ONE * 3, 1'b1));
        directed.push_back(make_beat(32'h00C0_0000, 1'b1, PRICE_ONE, 1'b1, PRICE_ONE + 1, 1'b0));
        directed.push_back(make_beat(32'h0000_0080, 1'b1, PRICE_ONE * 2, 1'b1, PRICE_ONE, 1'b1));
        directed.push_back(make_beat(32'h0000_007F, 1'b1, '0, 1'b0, '0, 1'b1));
        foreach (directed[k]) begin
            send_beat(directed[k]);
            idle_input();
        end

        for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
            idle_on = !(n >= 150 && n < 300);
            send_beat(random_beat());
            idle_input();
        end
        idle_on = 1'b1;
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d beats driven (%0d restarts), %0d results compared", sb.beats,
                 sb.restart_count, sb.checked);
        $display("products clipped on %0d results, dividend factor clamped on %0d",
                 sb.sat_count, sb.bad_count);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
